[src/vhsf_pkg.sv]
package vhsf_pkg;

    // Packet size limit; positions saturate at one below it
    localparam int MaxPacketBytesDef = 65536;

    localparam int CfgIndexW = 1;
    localparam int CfgDataW  = 3;

    // Register indexes
    localparam logic [CfgIndexW-1:0] REG_CODEC_SELECT = 1'd0;
    localparam logic [CfgIndexW-1:0] REG_REMOVE_MODE  = 1'd1;

    // Codec select codes
    localparam logic [2:0] CODEC_NONE  = 3'd0;
    localparam logic [2:0] CODEC_MPEG4 = 3'd1;
    localparam logic [2:0] CODEC_H264  = 3'd2;
    localparam logic [2:0] CODEC_HEVC  = 3'd3;
    localparam logic [2:0] CODEC_MPEG2 = 3'd4;
    localparam logic [2:0] CODEC_VC1   = 3'd5;

    // Remove mode codes
    localparam logic [1:0] MODE_KEY_ONLY    = 2'd0;
    localparam logic [1:0] MODE_ALL         = 2'd1;
    localparam logic [1:0] MODE_NONKEY_ONLY = 2'd2;

    // Start code prefix as seen in the three bytes before the code byte
    localparam logic [23:0] SC_PREFIX = 24'h000001;

    // MPEG-4 / MPEG-1/2 code bytes
    localparam logic [7:0] CODE_SEQ_HDR  = 8'hB3;
    localparam logic [7:0] CODE_EXT      = 8'hB5;
    localparam logic [7:0] CODE_VOP      = 8'hB6;
    // VC-1 sequence / entry point
    localparam logic [7:0] CODE_VC1_SEQ  = 8'h0F;
    localparam logic [7:0] CODE_VC1_ENTRY = 8'h0E;

    // H.264 NAL unit types
    localparam logic [4:0] NAL_SEI   = 5'd6;
    localparam logic [4:0] NAL_SPS   = 5'd7;
    localparam logic [4:0] NAL_PPS   = 5'd8;
    localparam logic [4:0] NAL_AUD   = 5'd9;
    localparam logic [4:0] NAL_SPSX  = 5'd13;
    localparam logic [4:0] NAL_SUBSPS = 5'd15;

    // HEVC NAL unit types
    localparam logic [5:0] NUT_VPS      = 6'd32;
    localparam logic [5:0] NUT_SPS      = 6'd33;
    localparam logic [5:0] NUT_PPS      = 6'd34;
    localparam logic [5:0] NUT_AUD      = 6'd35;
    localparam logic [5:0] NUT_PREFIX_SEI = 6'd39;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       key_frame;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [15:0] strip_bytes;
        logic        split_found;
    } t_out_word;

endpackage

[src/video_header_split_finder_top.sv]
// Header split finder for compressed video packets.
// Input channel (i_in_valid / o_in_ready / i_in_word): one packet byte per word,
// with the keyframe flag and a mark on the final byte. Output channel
// (o_out_valid / i_out_ready / o_out_word): one word per packet, issued for the
// final byte, giving the number of leading header bytes to strip and whether a
// split was found and allowed by the keyframe gate.
// Each byte is handled in the cycle it is taken: a shift of the last four bytes,
// the byte position and the header flags update at that edge, so one byte is
// taken every cycle while input ready is high. The result word is registered
// from its final byte into a single output register. Input ready is low only while
// that register is full and not being emptied in the same cycle, so while a
// result word waits on a stalled receiver no further byte is taken.
// Configuration (i_cfg_we / i_cfg_index / i_cfg_wdata) takes effect from the
// next byte. Reset clears registers, packet state and the output valid.
// Positions saturate at MAX_PACKET_BYTES - 1; strip counts saturate at 65535.
module video_header_split_finder_top
    import vhsf_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MaxPacketBytesDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_we,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_wdata
);

    localparam int PosW = $clog2(MAX_PACKET_BYTES);
    localparam int ExtW = (PosW > 16) ? PosW : 16;
    localparam logic [PosW-1:0] PosCap = PosW'(MAX_PACKET_BYTES - 1);

    logic [2:0]      r_codec;
    logic [1:0]      r_mode;
    logic [31:0]     r_recent;
    logic [PosW-1:0] r_pos;
    logic [PosW-1:0] r_zrb;
    logic            r_seen_vps;
    logic            r_seen_sps;
    logic            r_seen_pps;
    logic            r_done;
    logic [PosW-1:0] r_split;
    logic            r_out_valid;
    t_out_word       r_out;

    logic [31:0]     n_recent;
    logic [PosW-1:0] n_pos;
    logic [PosW-1:0] n_zrb;
    logic            n_seen_vps;
    logic            n_seen_sps;
    logic            n_seen_pps;
    logic            n_done;
    logic [PosW-1:0] n_split;
    t_out_word       n_out;

    logic            accept;
    logic            is_sc;
    logic [7:0]      b;
    logic [7:0]      code;
    logic [4:0]      h264_t;
    logic [5:0]      nut;
    logic [PosW-1:0] at;
    logic [PosW-1:0] at_zero;
    logic            gate;
    logic [ExtW-1:0] split_ext;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign b       = i_in_word.data_byte;
    assign n_recent = {r_recent[23:0], b};
    assign code    = b;
    assign h264_t  = code[4:0];
    assign nut     = code[6:1];
    assign is_sc   = !r_done && (r_recent[23:0] == SC_PREFIX);
    // offset of the first 00 of the code
    assign at      = (r_pos >= PosW'(3)) ? (r_pos - PosW'(3)) : '0;
    // move back over the zero run before the 01 byte
    assign at_zero = (r_zrb < at) ? r_zrb : at;

    always_comb begin
        n_seen_vps = r_seen_vps;
        n_seen_sps = r_seen_sps;
        n_seen_pps = r_seen_pps;
        n_done     = r_done;
        n_split    = r_split;
        if (is_sc) begin
            case (r_codec)
                CODEC_MPEG4: begin
                    if (code == CODE_SEQ_HDR || code == CODE_VOP) begin
                        n_done  = 1'b1;
                        n_split = at;
                    end
                end
                CODEC_H264: begin
                    if (h264_t == NAL_SPS) begin
                        n_seen_sps = 1'b1;
                    end else if (h264_t == NAL_PPS) begin
                        n_seen_pps = 1'b1;
                    end else if ((h264_t != NAL_SEI || r_seen_pps) && h264_t != NAL_AUD
                                 && h264_t != NAL_SPSX && h264_t != NAL_SUBSPS
                                 && r_seen_sps) begin
                        n_done  = 1'b1;
                        n_split = at_zero;
                    end
                end
                CODEC_HEVC: begin
                    if (nut == NUT_VPS) begin
                        n_seen_vps = 1'b1;
                    end else if (nut == NUT_SPS) begin
                        n_seen_sps = 1'b1;
                    end else if (nut == NUT_PPS) begin
                        n_seen_pps = 1'b1;
                    end else if ((nut != NUT_PREFIX_SEI || r_seen_pps) && nut != NUT_AUD
                                 && r_seen_vps && r_seen_sps) begin
                        n_done  = 1'b1;
                        n_split = at_zero;
                    end
                end
                CODEC_MPEG2: begin
                    if (code == CODE_SEQ_HDR) begin
                        n_seen_sps = 1'b1;
                    end else if (r_seen_sps && code != CODE_EXT) begin
                        n_done  = 1'b1;
                        n_split = at;
                    end
                end
                CODEC_VC1: begin
                    if (code == CODE_VC1_SEQ || code == CODE_VC1_ENTRY) begin
                        n_seen_sps = 1'b1;
                    end else if (r_seen_sps) begin
                        n_done  = 1'b1;
                        n_split = at;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_zrb = r_zrb;
        if (b == 8'h00 && (r_recent[7:0] != 8'h00 || r_pos == '0)) begin
            n_zrb = r_pos;
        end
        n_pos = (r_pos < PosCap) ? (r_pos + PosW'(1)) : r_pos;
    end

    always_comb begin
        gate = (r_mode == MODE_ALL) || (r_mode == MODE_KEY_ONLY && i_in_word.key_frame)
               || (r_mode == MODE_NONKEY_ONLY && !i_in_word.key_frame);
        split_ext = ExtW'(n_split);
        n_out.strip_bytes = 16'h0000;
        n_out.split_found = 1'b0;
        if (gate && n_done) begin
            n_out.split_found = 1'b1;
            n_out.strip_bytes = (split_ext > ExtW'(16'hFFFF)) ? 16'hFFFF : split_ext[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec     <= CODEC_NONE;
            r_mode      <= MODE_KEY_ONLY;
            r_recent    <= '1;
            r_pos       <= '0;
            r_zrb       <= '0;
            r_seen_vps  <= 1'b0;
            r_seen_sps  <= 1'b0;
            r_seen_pps  <= 1'b0;
            r_done      <= 1'b0;
            r_split     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CODEC_SELECT: r_codec <= i_cfg_wdata;
                    REG_REMOVE_MODE:  r_mode  <= i_cfg_wdata[1:0];
                    default: begin
                    end
                endcase
            end
            if (accept && i_in_word.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                if (i_in_word.last_byte) begin
                    // packet done: issue result, clear packet state
                    r_recent    <= '1;
                    r_pos       <= '0;
                    r_zrb       <= '0;
                    r_seen_vps  <= 1'b0;
                    r_seen_sps  <= 1'b0;
                    r_seen_pps  <= 1'b0;
                    r_done      <= 1'b0;
                    r_split     <= '0;
                end else begin
                    r_recent    <= n_recent;
                    r_pos       <= n_pos;
                    r_zrb       <= n_zrb;
                    r_seen_vps  <= n_seen_vps;
                    r_seen_sps  <= n_seen_sps;
                    r_seen_pps  <= n_seen_pps;
                    r_done      <= n_done;
                    r_split     <= n_split;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_word.last_byte) begin
            r_out <= n_out;
        end
    end

endmodule

[tb/tb_top.sv]
module tb_top;
    import vhsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Stimulus-only code bytes and NAL types not in the package
    localparam logic [7:0] CODE_VOS        = 8'hB0;
    localparam logic [7:0] CODE_GOP        = 8'hB8;
    localparam logic [7:0] CODE_PIC        = 8'h00;
    localparam logic [7:0] CODE_VC1_FRAME  = 8'h0D;
    localparam logic [7:0] CODE_VC1_FIELD  = 8'h0C;
    localparam logic [4:0] NAL_SLICE       = 5'd1;
    localparam logic [4:0] NAL_IDR         = 5'd5;
    localparam logic [5:0] NUT_TRAIL       = 6'd1;
    localparam logic [5:0] NUT_IDR         = 6'd19;
    localparam logic [5:0] NUT_SUFFIX_SEI  = 6'd40;
    localparam int         BYTES_PER_PHASE = 36;
    localparam int         STALL_LIMIT     = 2000;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 o_in_ready;
    t_in_word             in_word     = '0;
    logic                 o_out_valid;
    logic                 out_ready   = 1'b0;
    t_out_word            o_out_word;
    logic                 cfg_we      = 1'b0;
    logic [CfgIndexW-1:0] cfg_index   = '0;
    logic [CfgDataW-1:0]  cfg_wdata   = '0;

    video_header_split_finder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    t_in_word    pending_q[$];
    t_out_word   strip_expect_q[$];
    t_out_word   due_w;
    logic [7:0]  build_q[$];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          err_count      = 0;
    int          queued_items   = 0;
    int          stall_cycles   = 0;

    // Predictor state
    logic [2:0]  codec_cfg  = CODEC_NONE;
    logic [1:0]  mode_cfg   = MODE_KEY_ONLY;
    logic [31:0] shift_w    = 32'hFFFF_FFFF;
    int unsigned byte_pos   = 0;
    int unsigned zrun_start = 0;
    int unsigned cut_pos    = 0;
    bit          have_vps   = 1'b0;
    bit          have_sps   = 1'b0;
    bit          have_pps   = 1'b0;
    bit          cut_taken  = 1'b0;

    task automatic report_mismatch(input string msg);
        if (err_count < 100)
            $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    function void predict_split(input t_in_word w);
        int unsigned pos;
        int unsigned at;
        int unsigned back;
        logic [7:0]  prev;
        logic [7:0]  code;
        logic [4:0]  nal;
        logic [5:0]  nut;
        bit          hit;
        bit          gate;
        t_out_word   r;
        pos  = byte_pos;
        prev = shift_w[7:0];
        hit  = 1'b0;
        shift_w = {shift_w[23:0], w.data_byte};
        if (!cut_taken && shift_w[31:8] == SC_PREFIX) begin
            code = shift_w[7:0];
            at   = (pos >= 3) ? pos - 3 : 0;
            back = (zrun_start < at) ? zrun_start : at;
            nal  = code[4:0];
            nut  = code[6:1];
            case (codec_cfg)
                CODEC_MPEG4: begin
                    hit = (code == CODE_SEQ_HDR || code == CODE_VOP);
                end
                CODEC_H264: begin
                    if (nal == NAL_SPS)
                        have_sps = 1'b1;
                    else if (nal == NAL_PPS)
                        have_pps = 1'b1;
                    else if ((nal != NAL_SEI || have_pps) && nal != NAL_AUD &&
                             nal != NAL_SPSX && nal != NAL_SUBSPS)
                        hit = have_sps;
                    at = back;
                end
                CODEC_HEVC: begin
                    if (nut == NUT_VPS)
                        have_vps = 1'b1;
                    else if (nut == NUT_SPS)
                        have_sps = 1'b1;
                    else if (nut == NUT_PPS)
                        have_pps = 1'b1;
                    else if ((nut != NUT_PREFIX_SEI || have_pps) && nut != NUT_AUD)
                        hit = have_vps && have_sps;
                    at = back;
                end
                CODEC_MPEG2: begin
                    if (code == CODE_SEQ_HDR)
                        have_sps = 1'b1;
                    else
                        hit = have_sps && code != CODE_EXT;
                end
                CODEC_VC1: begin
                    if (code == CODE_VC1_SEQ || code == CODE_VC1_ENTRY)
                        have_sps = 1'b1;
                    else
                        hit = have_sps;
                end
                default: ;
            endcase
            if (hit) begin
                cut_taken = 1'b1;
                cut_pos   = at;
            end
        end
        if (w.data_byte == 8'h00 && (prev != 8'h00 || pos == 0))
            zrun_start = pos;
        if (byte_pos < MaxPacketBytesDef - 1)
            byte_pos++;
        if (w.last_byte) begin
            gate = (mode_cfg == MODE_ALL) || (mode_cfg == MODE_KEY_ONLY && w.key_frame) ||
                   (mode_cfg == MODE_NONKEY_ONLY && !w.key_frame);
            r.split_found = gate && cut_taken;
            r.strip_bytes = !r.split_found ? 16'd0 :
                            (cut_pos > 32'hFFFF) ? 16'hFFFF : cut_pos[15:0];
            strip_expect_q.push_back(r);
            shift_w    = 32'hFFFF_FFFF;
            byte_pos   = 0;
            zrun_start = 0;
            cut_pos    = 0;
            have_vps   = 1'b0;
            have_sps   = 1'b0;
            have_pps   = 1'b0;
            cut_taken  = 1'b0;
        end
    endfunction

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready)
                predict_split(in_word);
            if (!in_valid || o_in_ready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_word  <= pending_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (strip_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word strip=%0d found=%0b",
                                          o_out_word.strip_bytes, o_out_word.split_found));
            end else begin
                due_w = strip_expect_q.pop_front();
                if (o_out_word.strip_bytes !== due_w.strip_bytes)
                    report_mismatch($sformatf("strip_bytes got %0d want %0d",
                                              o_out_word.strip_bytes, due_w.strip_bytes));
                if (o_out_word.split_found !== due_w.split_found)
                    report_mismatch($sformatf("split_found got %0b want %0b",
                                              o_out_word.split_found, due_w.split_found));
            end
        end
    end

    // Watchdog: no word moving while work is outstanding
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((pending_q.size() > 0 || in_valid || strip_expect_q.size() > 0) &&
                !(in_valid && o_in_ready) && !(o_out_valid && out_ready))
                stall_cycles++;
            else
                stall_cycles = 0;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic set_config(input logic [2:0] codec, input logic [1:0] mode);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CODEC_SELECT;
        cfg_wdata <= codec;
        @(posedge i_clk);
        cfg_index <= REG_REMOVE_MODE;
        cfg_wdata <= CfgDataW'(mode);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        codec_cfg = codec;
        mode_cfg  = mode;
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || in_valid || strip_expect_q.size() > 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic flush_packet(input bit key);
        t_in_word w;
        for (int i = 0; i < build_q.size(); i++) begin
            w.data_byte = build_q[i];
            w.key_frame = key;
            w.last_byte = (i == build_q.size() - 1);
            pending_q.push_back(w);
        end
        queued_items += build_q.size();
        build_q = {};
    endtask

    function automatic logic [7:0] h264_nal(input logic [4:0] t);
        return {3'($urandom), t};
    endfunction

    function automatic logic [7:0] hevc_nut(input logic [5:0] n);
        return {1'($urandom), n, 1'($urandom)};
    endfunction

    function automatic logic [7:0] pool_code(input logic [2:0] codec);
        logic [4:0] t;
        logic [5:0] n;
        case (codec)
            CODEC_H264: begin
                case ($urandom_range(8))
                    0: t = NAL_SEI;
                    1: t = NAL_SPS;
                    2: t = NAL_PPS;
                    3: t = NAL_AUD;
                    4: t = NAL_SPSX;
                    5: t = NAL_SUBSPS;
                    6: t = NAL_IDR;
                    7: t = NAL_SLICE;
                    default: t = 5'($urandom);
                endcase
                return h264_nal(t);
            end
            CODEC_HEVC: begin
                case ($urandom_range(8))
                    0: n = NUT_VPS;
                    1: n = NUT_SPS;
                    2: n = NUT_PPS;
                    3: n = NUT_AUD;
                    4: n = NUT_PREFIX_SEI;
                    5: n = NUT_IDR;
                    6: n = NUT_TRAIL;
                    7: n = NUT_SUFFIX_SEI;
                    default: n = 6'($urandom);
                endcase
                return hevc_nut(n);
            end
            default: begin
                case ($urandom_range(9))
                    0: return CODE_SEQ_HDR;
                    1: return CODE_EXT;
                    2: return CODE_VOP;
                    3: return CODE_VOS;
                    4: return CODE_GOP;
                    5: return CODE_PIC;
                    6: return CODE_VC1_SEQ;
                    7: return CODE_VC1_ENTRY;
                    8: return CODE_VC1_FRAME;
                    default: return 8'($urandom);
                endcase
            end
        endcase
    endfunction

    // Start code with occasional extra leading zeros and a short random tail
    task automatic add_code(input logic [7:0] code);
        int extra;
        extra = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
        repeat (extra) build_q.push_back(8'h00);
        build_q.push_back(8'h00);
        build_q.push_back(8'h00);
        build_q.push_back(8'h01);
        build_q.push_back(code);
        repeat ($urandom_range(3)) build_q.push_back(8'($urandom));
    endtask

    task automatic queue_packet(input logic [2:0] codec);
        int         kind;
        logic [7:0] codes[$];
        kind = $urandom_range(99);
        repeat ($urandom_range(2)) build_q.push_back(8'($urandom));
        if (kind < 70) begin
            // well-formed header sequence then a picture
            case (codec)
                CODEC_H264: begin
                    if ($urandom_range(3) == 0) codes.push_back(h264_nal(NAL_AUD));
                    codes.push_back(h264_nal(NAL_SPS));
                    if ($urandom_range(2) == 0) codes.push_back(h264_nal(NAL_SEI));
                    if ($urandom_range(5) != 0) codes.push_back(h264_nal(NAL_PPS));
                    if ($urandom_range(2) == 0) codes.push_back(h264_nal(NAL_SEI));
                    codes.push_back(h264_nal($urandom_range(1) ? NAL_IDR : NAL_SLICE));
                end
                CODEC_HEVC: begin
                    if ($urandom_range(3) == 0) codes.push_back(hevc_nut(NUT_AUD));
                    if ($urandom_range(7) != 0) codes.push_back(hevc_nut(NUT_VPS));
                    codes.push_back(hevc_nut(NUT_SPS));
                    if ($urandom_range(5) != 0) codes.push_back(hevc_nut(NUT_PPS));
                    if ($urandom_range(2) == 0) codes.push_back(hevc_nut(NUT_PREFIX_SEI));
                    codes.push_back(hevc_nut(6'($urandom_range(21))));
                end
                CODEC_MPEG4: begin
                    if ($urandom_range(1)) codes.push_back(CODE_VOS);
                    if ($urandom_range(1)) codes.push_back(CODE_EXT);
                    codes.push_back($urandom_range(1) ? CODE_VOP : CODE_SEQ_HDR);
                end
                CODEC_MPEG2: begin
                    codes.push_back(CODE_SEQ_HDR);
                    if ($urandom_range(1)) codes.push_back(CODE_EXT);
                    codes.push_back($urandom_range(1) ? CODE_GOP : CODE_PIC);
                end
                CODEC_VC1: begin
                    codes.push_back(CODE_VC1_SEQ);
                    if ($urandom_range(1)) codes.push_back(CODE_VC1_ENTRY);
                    codes.push_back($urandom_range(1) ? CODE_VC1_FRAME : CODE_VC1_FIELD);
                end
                default: begin
                    repeat ($urandom_range(4, 2)) codes.push_back(pool_code(3'($urandom)));
                end
            endcase
            repeat ($urandom_range(2)) codes.push_back(pool_code(codec));
        end else if (kind < 90) begin
            repeat ($urandom_range(5, 1)) codes.push_back(pool_code(codec));
        end
        foreach (codes[i]) add_code(codes[i]);
        if (kind >= 90) begin
            // zero-heavy noise
            repeat ($urandom_range(24, 1)) begin
                case ($urandom_range(3))
                    0, 1: build_q.push_back(8'h00);
                    2: build_q.push_back(8'h01);
                    default: build_q.push_back(8'($urandom));
                endcase
            end
        end
        flush_packet(1'($urandom));
    endtask

    initial begin
        int         send_pct[3];
        int         recv_pct[3];
        int         target;
        logic [2:0] codec;
        logic [1:0] mode;
        send_pct = '{24, 62, 0};
        recv_pct = '{62, 24, 0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int prof = 0; prof < 3; prof++) begin
            send_idle_pct  = send_pct[prof];
            recv_stall_pct = recv_pct[prof];
            if (prof == 0) begin
                // single-byte packets at both byte extremes, then a zero-run split
                set_config(CODEC_H264, MODE_KEY_ONLY);
                build_q = '{8'hFF};
                flush_packet(1'b0);
                build_q = '{8'h00};
                flush_packet(1'b1);
                build_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'hAA, 8'h00,
                            8'h00, 8'h00, 8'h01, 8'h68, 8'h00, 8'h00, 8'h01, 8'h65};
                flush_packet(1'b1);
                wait_drained();
            end
            for (int k = 0; k < 10; k++) begin
                if (k < 8) begin
                    codec = 3'(k);
                    mode  = 2'((k + prof) % 4);
                end else begin
                    codec = (k == 8) ? CODEC_H264 : CODEC_HEVC;
                    mode  = MODE_ALL;
                end
                set_config(codec, mode);
                target = queued_items + BYTES_PER_PHASE;
                while (queued_items < target)
                    queue_packet(codec);
                wait_drained();
            end
        end

        repeat (10) @(negedge i_clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
